@@ sv/hkr_pkg.sv @@
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared constants for the keyboard report differ.
// ----------------------------------------------------------------------------
package hkr_pkg;

   localparam int KEY_SLOTS_DEFAULT = 6;
   localparam int INPUT_SLOTS       = 6;
   localparam int CODE_W            = 8;
   localparam int MAX_EVENTS        = 12;
   localparam int EVENT_CNT_W       = $clog2(MAX_EVENTS + 1);
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [CODE_W-1:0] MIN_KEY = 8'h04;

endpackage

@@ sv/hkr_queue.sv @@
// ----------------------------------------------------------------------------
// hkr_queue
// Small FIFO holding classified reports between front and back.
// ----------------------------------------------------------------------------
module hkr_queue import hkr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/hkr_front.sv @@
// ----------------------------------------------------------------------------
// hkr_front
// Accepts a report, compares it with the previous one and queues the
// release/press/repeat work for the back end.
// ----------------------------------------------------------------------------
module hkr_front import hkr_pkg::*; #(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT,
   parameter int JOB_W     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [CODE_W-1:0] modifier_bits,
   input  logic [CODE_W-1:0] slot_code [INPUT_SLOTS],
   input  logic              queue_full,
   output logic              queue_push,
   output logic [JOB_W-1:0]  queue_data
);

   typedef struct packed {
      logic [KEY_SLOTS-1:0][CODE_W-1:0] old_codes;
      logic [KEY_SLOTS-1:0][CODE_W-1:0] new_codes;
      logic [CODE_W-1:0]                old_mods;
      logic [CODE_W-1:0]                new_mods;
      logic [KEY_SLOTS-1:0]             rel_mask;
      logic [KEY_SLOTS-1:0]             press_mask;
      logic                             repeat_key;
      logic [CODE_W-1:0]                last_key;
   } job_type;

   logic [KEY_SLOTS-1:0][CODE_W-1:0] prev_codes_ff;
   logic [CODE_W-1:0]                prev_mods_ff;
   logic [CODE_W-1:0]                prev_last_ff;
   logic [KEY_SLOTS-1:0][CODE_W-1:0] now_codes;
   logic [KEY_SLOTS-1:0]             old_in_new, new_in_old;
   logic [KEY_SLOTS-1:0]             rel_mask, press_mask;
   logic [CODE_W-1:0]                last_key;
   logic                             sets_equal, repeat_key, accept;
   job_type                          job;

   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
      if (i < INPUT_SLOTS) begin : g_port
         assign now_codes[i] = slot_code[i];
      end else begin : g_zero
         assign now_codes[i] = '0;
      end
   end

   always_comb begin
      old_in_new = '0;
      new_in_old = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_codes_ff[i] == now_codes[j]) begin
               old_in_new[i] = 1'b1;
            end
            if (now_codes[i] == prev_codes_ff[j]) begin
               new_in_old[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      last_key = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         rel_mask[i]   = (prev_codes_ff[i] >= MIN_KEY) && !old_in_new[i];
         press_mask[i] = (now_codes[i] >= MIN_KEY) && !new_in_old[i];
         if (now_codes[i] >= MIN_KEY) begin
            last_key = now_codes[i];
         end
      end
   end

   assign sets_equal = (&old_in_new) && (&new_in_old);
   assign repeat_key = (last_key != '0) && sets_equal && (prev_last_ff == last_key);
   assign accept     = push && !queue_full;

   always_comb begin
      job.old_codes  = prev_codes_ff;
      job.new_codes  = now_codes;
      job.old_mods   = prev_mods_ff;
      job.new_mods   = modifier_bits;
      job.rel_mask   = rel_mask;
      job.press_mask = press_mask;
      job.repeat_key = repeat_key;
      job.last_key   = last_key;
   end

   // reports that cause no event only update the state
   assign queue_push = accept && ((|rel_mask) || (|press_mask) || repeat_key);
   assign queue_data = JOB_W'(job);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_codes_ff <= '0;
         prev_mods_ff  <= '0;
         prev_last_ff  <= '0;
      end else if (accept) begin
         prev_codes_ff <= now_codes;
         prev_mods_ff  <= modifier_bits;
         prev_last_ff  <= last_key;
      end
   end

endmodule

@@ sv/hkr_back.sv @@
// ----------------------------------------------------------------------------
// hkr_back
// Serializes one queued report into key event beats through a registered
// output stage, one per cycle while that stage is not stalled by rsp_pop.
// ----------------------------------------------------------------------------
module hkr_back import hkr_pkg::*; #(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT,
   parameter int JOB_W     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  logic [JOB_W-1:0]  queue_data,
   output logic              queue_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CODE_W-1:0] rsp_event_key,
   output logic [CODE_W-1:0] rsp_event_modifiers,
   output logic              rsp_event_pressed,
   output logic              rsp_event_final
);

   typedef struct packed {
      logic [KEY_SLOTS-1:0][CODE_W-1:0] old_codes;
      logic [KEY_SLOTS-1:0][CODE_W-1:0] new_codes;
      logic [CODE_W-1:0]                old_mods;
      logic [CODE_W-1:0]                new_mods;
      logic [KEY_SLOTS-1:0]             rel_mask;
      logic [KEY_SLOTS-1:0]             press_mask;
      logic                             repeat_key;
      logic [CODE_W-1:0]                last_key;
   } job_type;

   localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   job_type                  job_ff, job_in, job_new;
   logic                     job_valid_ff, job_valid_in;
   logic [EVENT_CNT_W-1:0]   count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]        key_ff, key_in, mods_ff, mods_in;
   logic                     pressed_ff, pressed_in, final_ff, final_in;
   logic [KEY_SLOTS-1:0]     rel_pick, press_pick, rel_rest, press_rest;
   logic [SLOT_W-1:0]        rel_idx, press_idx;
   logic                     out_free, emit, load, more;

   assign job_new  = job_type'(queue_data);
   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = job_valid_ff && out_free;

   // lowest pending slot first
   assign rel_pick   = job_ff.rel_mask & (~job_ff.rel_mask + 1'b1);
   assign press_pick = job_ff.press_mask & (~job_ff.press_mask + 1'b1);
   assign rel_rest   = job_ff.rel_mask & ~rel_pick;
   assign press_rest = job_ff.press_mask & ~press_pick;

   always_comb begin
      rel_idx   = '0;
      press_idx = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (rel_pick[i]) begin
            rel_idx = SLOT_W'(i);
         end
         if (press_pick[i]) begin
            press_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      key_in     = job_ff.last_key;
      mods_in    = job_ff.new_mods;
      pressed_in = 1'b1;
      more       = 1'b0;
      job_in     = job_ff;
      if (|job_ff.rel_mask) begin
         key_in          = job_ff.old_codes[rel_idx];
         mods_in         = job_ff.old_mods;
         pressed_in      = 1'b0;
         more            = (|rel_rest) || (|job_ff.press_mask) || job_ff.repeat_key;
         job_in.rel_mask = rel_rest;
      end else if (|job_ff.press_mask) begin
         key_in            = job_ff.new_codes[press_idx];
         more              = (|press_rest) || job_ff.repeat_key;
         job_in.press_mask = press_rest;
      end else begin
         job_in.repeat_key = 1'b0;
      end
      final_in = !more || (count_ff == EVENT_CNT_W'(MAX_EVENTS - 1));
   end

   assign load      = (!job_valid_ff || (emit && final_in)) && !queue_empty;
   assign queue_pop = load;

   always_comb begin
      job_valid_in = job_valid_ff;
      count_in     = count_ff;
      if (emit) begin
         count_in = count_ff + 1'b1;
         if (final_in) begin
            job_valid_in = 1'b0;
         end
      end
      if (load) begin
         job_valid_in = 1'b1;
         count_in     = '0;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_new;
      end else if (emit) begin
         job_ff <= job_in;
      end
      if (emit) begin
         key_ff     <= key_in;
         mods_ff    <= mods_in;
         pressed_ff <= pressed_in;
         final_ff   <= final_in;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_event_key       = key_ff;
   assign rsp_event_modifiers = mods_ff;
   assign rsp_event_pressed   = pressed_ff;
   assign rsp_event_final     = final_ff;

`ifndef SYNTHESIS
   a_key_min: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (key_ff >= MIN_KEY))
      else $error("event key below minimum");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= EVENT_CNT_W'(MAX_EVENTS))
      else $error("event count overflow");

   a_job_holds: assert property (@(posedge clock) disable iff (reset)
      (emit && !final_in) |=> job_valid_ff)
      else $error("job dropped before final event");

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> ((|job_ff.rel_mask) || (|job_ff.press_mask) || job_ff.repeat_key))
      else $error("active job has no pending event");
`endif

endmodule

@@ sv/hid_keyboard_report_to_key_events.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events
// Keyboard report differ: turns boot keyboard reports into key release,
// press and repeat event beats.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  report  | req_modifier_bits, req_slot_*  | req_push / req_full
//  event   | rsp_event_*                    | rsp_pop / rsp_empty
//
//  The front compares each report with the stored report and queues its
//  work. The back emits one event per cycle while the output is not
//  stalled, and at most 12 events per report.
//  Sync reset clears the stored report, the queue and the output stage.
//  The two-entry queue lets reports enter while events drain or stall.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_key_events import hkr_pkg::*; #(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [CODE_W-1:0] req_modifier_bits,
   input  logic [CODE_W-1:0] req_slot_code_0,
   input  logic [CODE_W-1:0] req_slot_code_1,
   input  logic [CODE_W-1:0] req_slot_code_2,
   input  logic [CODE_W-1:0] req_slot_code_3,
   input  logic [CODE_W-1:0] req_slot_code_4,
   input  logic [CODE_W-1:0] req_slot_code_5,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CODE_W-1:0] rsp_event_key,
   output logic [CODE_W-1:0] rsp_event_modifiers,
   output logic              rsp_event_pressed,
   output logic              rsp_event_final
);

   localparam int JOB_W = 2 * KEY_SLOTS * CODE_W + 3 * CODE_W + 2 * KEY_SLOTS + 1;

   logic [CODE_W-1:0] slot_code [INPUT_SLOTS];
   logic              q_push, q_full, q_pop, q_empty;
   logic [JOB_W-1:0]  q_wdata, q_rdata;

   assign slot_code[0] = req_slot_code_0;
   assign slot_code[1] = req_slot_code_1;
   assign slot_code[2] = req_slot_code_2;
   assign slot_code[3] = req_slot_code_3;
   assign slot_code[4] = req_slot_code_4;
   assign slot_code[5] = req_slot_code_5;
   assign req_full     = q_full;

   hkr_front #(
      .KEY_SLOTS (KEY_SLOTS),
      .JOB_W     (JOB_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .modifier_bits (req_modifier_bits),
      .slot_code     (slot_code),
      .queue_full    (q_full),
      .queue_push    (q_push),
      .queue_data    (q_wdata)
   );

   hkr_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   hkr_back #(
      .KEY_SLOTS (KEY_SLOTS),
      .JOB_W     (JOB_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_empty         (q_empty),
      .queue_data          (q_rdata),
      .queue_pop           (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_event_key       (rsp_event_key),
      .rsp_event_modifiers (rsp_event_modifiers),
      .rsp_event_pressed   (rsp_event_pressed),
      .rsp_event_final     (rsp_event_final)
   );

endmodule
